// ===== rtl/ang_pkg.sv =====
package ang_pkg;

   localparam int CHANNELS      = 2;
   localparam int SAMPLE_BITS   = 24;
   localparam int FRAC_BITS     = 24;
   localparam int COEFF_BITS    = 24;
   localparam int LEVEL_BITS    = 24;
   localparam int GAIN_BITS     = FRAC_BITS + 1;
   localparam int ENV_BITS      = SAMPLE_BITS + 1;
   localparam int MUL_BITS      = (ENV_BITS > GAIN_BITS) ? ENV_BITS : GAIN_BITS;
   localparam int PROD_BITS     = 2 * MUL_BITS;
   localparam int CH_IDX_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 24;

   localparam logic [GAIN_BITS-1:0]  GAIN_ONE  = GAIN_BITS'(1) << FRAC_BITS;
   localparam logic [PROD_BITS:0]    ROUND_UP  = (PROD_BITS + 1)'((1 << FRAC_BITS) - 1);

   localparam logic [LEVEL_BITS-1:0] THRESHOLD_RESET = LEVEL_BITS'(8389);
   localparam logic [COEFF_BITS-1:0] ATTACK_RESET    = COEFF_BITS'(16431303);
   localparam logic [COEFF_BITS-1:0] RELEASE_RESET   = COEFF_BITS'(16773721);
   localparam logic [COEFF_BITS-1:0] OPEN_RESET      = COEFF_BITS'(16431303);
   localparam logic [COEFF_BITS-1:0] CLOSE_RESET     = COEFF_BITS'(16770227);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_GATE_ENABLE = 3'd0,
      REG_THRESHOLD   = 3'd1,
      REG_ATTACK      = 3'd2,
      REG_RELEASE     = 3'd3,
      REG_OPEN        = 3'd4,
      REG_CLOSE       = 3'd5
   } ang_reg_type;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      logic                  gate_enable;
      logic [LEVEL_BITS-1:0] threshold_level;
      logic [COEFF_BITS-1:0] attack_coeff;
      logic [COEFF_BITS-1:0] release_coeff;
      logic [COEFF_BITS-1:0] open_coeff;
      logic [COEFF_BITS-1:0] close_coeff;
   } ang_cfg_type;

   typedef struct packed {
      logic                   load_req;
      logic                   env_op;
      logic                   env_upd;
      logic                   gain_op;
      logic                   gain_upd;
      logic                   ch_op;
      logic                   ch_upd;
      logic                   rsp_load;
      logic [CH_IDX_BITS-1:0] ch_sel;
   } ang_cmd_type;

endpackage

// ===== rtl/ang_if.sv =====
interface ang_req_if;
   import ang_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample_ch0;
   sample_type sample_ch1;
   modport source (output valid, output sample_ch0, output sample_ch1, input ready);
   modport sink (input valid, input sample_ch0, input sample_ch1, output ready);
endinterface

interface ang_rsp_if;
   import ang_pkg::*;
   logic                 valid;
   logic                 ready;
   sample_type           out_ch0;
   sample_type           out_ch1;
   logic [GAIN_BITS-1:0] gain_level;
   modport source (output valid, output out_ch0, output out_ch1, output gain_level,
                   input ready);
   modport sink (input valid, input out_ch0, input out_ch1, input gain_level,
                 output ready);
endinterface

interface ang_csr_if;
   import ang_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ang_regs.sv =====
module ang_regs (
   input  logic                clock,
   input  logic                reset,
   ang_csr_if.sink             csr,
   output ang_pkg::ang_cfg_type cfg
);
   import ang_pkg::*;

   ang_cfg_type cfg_ff;
   ang_cfg_type cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (ang_reg_type'(csr.index))
            REG_GATE_ENABLE: cfg_in.gate_enable     = csr.data[0];
            REG_THRESHOLD:   cfg_in.threshold_level = LEVEL_BITS'(csr.data);
            REG_ATTACK:      cfg_in.attack_coeff    = COEFF_BITS'(csr.data);
            REG_RELEASE:     cfg_in.release_coeff   = COEFF_BITS'(csr.data);
            REG_OPEN:        cfg_in.open_coeff      = COEFF_BITS'(csr.data);
            REG_CLOSE:       cfg_in.close_coeff     = COEFF_BITS'(csr.data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gate_enable     <= 1'b0;
         cfg_ff.threshold_level <= THRESHOLD_RESET;
         cfg_ff.attack_coeff    <= ATTACK_RESET;
         cfg_ff.release_coeff   <= RELEASE_RESET;
         cfg_ff.open_coeff      <= OPEN_RESET;
         cfg_ff.close_coeff     <= CLOSE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/ang_ctrl.sv =====
module ang_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 gate_enable,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ang_pkg::ang_cmd_type cmd
);
   import ang_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ENV_OP,
      ST_ENV_MUL,
      ST_ENV_UPD,
      ST_GAIN_OP,
      ST_GAIN_MUL,
      ST_GAIN_UPD,
      ST_CH_OP,
      ST_CH_MUL,
      ST_CH_UPD,
      ST_FINISH
   } state_type;

   state_type              state_ff, state_in;
   logic [CH_IDX_BITS-1:0] ch_ff, ch_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.ch_sel   = ch_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = gate_enable ? ST_ENV_OP : ST_FINISH;
            end
         end
         ST_ENV_OP: begin
            cmd.env_op = 1'b1;
            state_in   = ST_ENV_MUL;
         end
         ST_ENV_MUL: state_in = ST_ENV_UPD;
         ST_ENV_UPD: begin
            cmd.env_upd = 1'b1;
            state_in    = ST_GAIN_OP;
         end
         ST_GAIN_OP: begin
            cmd.gain_op = 1'b1;
            state_in    = ST_GAIN_MUL;
         end
         ST_GAIN_MUL: state_in = ST_GAIN_UPD;
         ST_GAIN_UPD: begin
            cmd.gain_upd = 1'b1;
            ch_in        = '0;
            state_in     = ST_CH_OP;
         end
         ST_CH_OP: begin
            cmd.ch_op = 1'b1;
            state_in  = ST_CH_MUL;
         end
         ST_CH_MUL: state_in = ST_CH_UPD;
         ST_CH_UPD: begin
            cmd.ch_upd = 1'b1;
            if (ch_ff == CH_IDX_BITS'(CHANNELS - 1)) begin
               state_in = ST_FINISH;
            end else begin
               ch_in    = ch_ff + 1'b1;
               state_in = ST_CH_OP;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/ang_dp.sv =====
module ang_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  ang_pkg::ang_cfg_type          cfg,
   input  ang_pkg::ang_cmd_type          cmd,
   input  ang_pkg::sample_type           req_sample [ang_pkg::CHANNELS],
   output ang_pkg::sample_type           rsp_sample [ang_pkg::CHANNELS],
   output logic [ang_pkg::GAIN_BITS-1:0] rsp_gain
);
   import ang_pkg::*;

   sample_type           samp_ff [CHANNELS];
   sample_type           work_ff [CHANNELS];
   sample_type           rsp_ff  [CHANNELS];
   logic [GAIN_BITS-1:0] rsp_gain_ff;
   logic                 bypass_ff;
   logic [ENV_BITS-1:0]  env_ff;
   logic [GAIN_BITS-1:0] gain_ff;
   logic                 up_ff;
   logic [MUL_BITS-1:0]  a_ff, b_ff;
   logic [PROD_BITS-1:0] prod_ff;

   logic [ENV_BITS-1:0]  mag [CHANNELS];
   logic [ENV_BITS-1:0]  peak;
   logic [ENV_BITS-1:0]  env_diff;
   logic [GAIN_BITS-1:0] target, gain_diff;
   logic                 peak_up, gain_up;
   logic [COEFF_BITS-1:0] env_coeff, gain_coeff;
   logic [MUL_BITS-1:0]  step;
   logic [SAMPLE_BITS-1:0] q_floor, q_ceil;

   function automatic logic [MUL_BITS-1:0] pole_k(input logic [COEFF_BITS-1:0] c);
      logic [FRAC_BITS:0] k;
      k = (FRAC_BITS + 1)'(1) << FRAC_BITS;
      k = k - (FRAC_BITS + 1)'(c);
      return MUL_BITS'(k);
   endfunction

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         if (samp_ff[c][SAMPLE_BITS-1]) begin
            mag[c] = ENV_BITS'(0) - ENV_BITS'({1'b1, samp_ff[c]});
         end else begin
            mag[c] = ENV_BITS'(samp_ff[c]);
         end
      end
      peak = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         if (mag[c] > peak) begin
            peak = mag[c];
         end
      end
   end

   assign peak_up   = (peak >= env_ff);
   assign env_diff  = peak_up ? (peak - env_ff) : (env_ff - peak);
   assign env_coeff = (peak > env_ff) ? cfg.attack_coeff : cfg.release_coeff;

   assign target     = (env_ff >= ENV_BITS'(cfg.threshold_level)) ? GAIN_ONE : '0;
   assign gain_up    = (target >= gain_ff);
   assign gain_diff  = gain_up ? (target - gain_ff) : (gain_ff - target);
   assign gain_coeff = (target > gain_ff) ? cfg.open_coeff : cfg.close_coeff;

   logic [PROD_BITS:0] prod_round;
   assign prod_round = {1'b0, prod_ff} + ROUND_UP;
   assign step       = prod_round[FRAC_BITS +: MUL_BITS];
   assign q_floor    = prod_ff[FRAC_BITS +: SAMPLE_BITS];
   assign q_ceil     = prod_round[FRAC_BITS +: SAMPLE_BITS];

   always_ff @(posedge clock) begin
      prod_ff <= a_ff * b_ff;
      if (cmd.load_req) begin
         samp_ff   <= req_sample;
         bypass_ff <= !cfg.gate_enable;
      end
      if (cmd.env_op) begin
         a_ff  <= pole_k(env_coeff);
         b_ff  <= MUL_BITS'(env_diff);
         up_ff <= peak_up;
      end
      if (cmd.gain_op) begin
         a_ff  <= pole_k(gain_coeff);
         b_ff  <= MUL_BITS'(gain_diff);
         up_ff <= gain_up;
      end
      if (cmd.ch_op) begin
         a_ff <= MUL_BITS'(mag[cmd.ch_sel]);
         b_ff <= MUL_BITS'(gain_ff);
      end
      if (cmd.ch_upd) begin
         if (samp_ff[cmd.ch_sel][SAMPLE_BITS-1]) begin
            work_ff[cmd.ch_sel] <= sample_type'(SAMPLE_BITS'(0) - q_ceil);
         end else begin
            work_ff[cmd.ch_sel] <= sample_type'(q_floor);
         end
      end
      if (cmd.rsp_load) begin
         if (bypass_ff) begin
            rsp_ff      <= samp_ff;
            rsp_gain_ff <= GAIN_ONE;
         end else begin
            rsp_ff      <= work_ff;
            rsp_gain_ff <= gain_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff  <= '0;
         gain_ff <= '0;
      end else begin
         if (cmd.env_upd) begin
            env_ff <= up_ff ? env_ff + ENV_BITS'(step) : env_ff - ENV_BITS'(step);
         end
         if (cmd.gain_upd) begin
            gain_ff <= up_ff ? gain_ff + GAIN_BITS'(step) : gain_ff - GAIN_BITS'(step);
         end
      end
   end

   assign rsp_sample = rsp_ff;
   assign rsp_gain   = rsp_gain_ff;

endmodule

// ===== rtl/audio_noise_gate_core.sv =====
// Channel    Dir  Payload
// req_chan   in   sample_ch0, sample_ch1 (signed, Q1.23)
// rsp_chan   out  out_ch0, out_ch1 (signed, Q1.23), gain_level (Q1.24)
// csr_chan   in   index, data (register write, always ready)
//
// One frame at a time. Gate enabled: the single shared 25x25 multiplier serves the
// envelope, the gain and each channel in turn. Gate disabled: the samples pass
// straight to the output register with unity gain.
// Synchronous reset clears the envelope, the gain and the handshakes and sets the registers to their reset values.
// A stalled response holds in the output register; the next request is taken and
// worked on meanwhile, its result waiting until that register frees.
module audio_noise_gate_core (
   input  logic      clock,
   input  logic      reset,
   ang_req_if.sink   req_chan,
   ang_rsp_if.source rsp_chan,
   ang_csr_if.sink   csr_chan
);
   import ang_pkg::*;

   ang_cfg_type          cfg;
   ang_cmd_type          cmd;
   sample_type           req_sample [CHANNELS];
   sample_type           rsp_sample [CHANNELS];
   logic [GAIN_BITS-1:0] rsp_gain;

   assign req_sample[0] = req_chan.sample_ch0;
   assign req_sample[1] = req_chan.sample_ch1;

   assign rsp_chan.out_ch0    = rsp_sample[0];
   assign rsp_chan.out_ch1    = rsp_sample[1];
   assign rsp_chan.gain_level = rsp_gain;

   ang_regs u_regs (
      .clock (clock),
      .reset (reset),
      .csr   (csr_chan),
      .cfg   (cfg)
   );

   ang_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .gate_enable (cfg.gate_enable),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .cmd         (cmd)
   );

   ang_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .req_sample (req_sample),
      .rsp_sample (rsp_sample),
      .rsp_gain   (rsp_gain)
   );

endmodule

// ===== rtl/ang_check.sv =====
module ang_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [ang_pkg::GAIN_BITS-1:0] rsp_gain
);
   import ang_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_gain))
      else $error("response dropped or changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a frame is in progress");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response raised in the cycle after a request");

   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_gain <= GAIN_ONE)
      else $error("gain above unity");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind audio_noise_gate_core ang_check u_ang_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_gain  (rsp_chan.gain_level)
);
